### hdl/pbc_pkg.sv
// Shared types, blend mode codes and the rounded divide-by-255 helper
// for the pixel blend and coverage pipeline. No dependencies.
package pbc_pkg;

  localparam int ChanW   = 8;
  localparam int NumChan = 4;
  localparam int ProdW   = 2 * ChanW;
  localparam logic [ChanW-1:0] ChanMax = 8'd255;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [NumChan-1:0][ChanW-1:0] pix_t;
  typedef logic [NumChan-1:0][ProdW-1:0] prod_t;

  typedef enum logic [1:0] {
    MODE_SRC      = 2'd0,
    MODE_SRCOVER  = 2'd1,
    MODE_DSTOVER  = 2'd2,
    MODE_MULTIPLY = 2'd3
  } blend_mode_t;

  // Word passed from the blend half to the coverage half of the pipeline.
  typedef struct packed {
    pix_t  blend;
    pix_t  dst;
    chan_t cov;
  } blend_word_t;

  // Rounded x/255 for a product of two channels: floor((x + 127) / 255).
  // The sum v stays below 65535, where (v + 1 + (v >> 8)) >> 8 is exact.
  function automatic chan_t div255r(input logic [ProdW-1:0] x);
    logic [ProdW:0] v;
    logic [ProdW:0] q;
    v = {1'b0, x} + (ProdW+1)'(127);
    q = (v + (ProdW+1)'(1) + (v >> 8)) >> 8;
    return q[ChanW-1:0];
  endfunction

endpackage

### hdl/pbc_blend.sv
// Blend half of the pipeline: stage one forms the channel products,
// stage two scales them by 1/255 and sums with saturation. Uses pbc_pkg.
module pbc_blend import pbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  blend_mode_t mode,
  input  logic        in_valid,
  output logic        in_ready,
  input  pix_t        src,
  input  pix_t        dst,
  input  chan_t       cov,
  output logic        out_valid,
  input  logic        out_ready,
  output blend_word_t out_word
);

  logic  v1, v2;
  logic  rdy1, rdy2;
  pix_t  s1, d1;
  chan_t cov1;
  prod_t p_sd, p_sda, p_dsa;
  pix_t  blend_next;

  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
    end
  end

  // Stage one: the three products each mode may need.
  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      s1   <= src;
      d1   <= dst;
      cov1 <= cov;
      for (int i = 0; i < NumChan; i++) begin
        p_sd[i]  <= src[i] * dst[i];
        p_sda[i] <= src[i] * (ChanMax - dst[NumChan-1]);
        p_dsa[i] <= dst[i] * (ChanMax - src[NumChan-1]);
      end
    end
  end

  always_comb begin
    logic [ChanW+1:0] sum;
    for (int i = 0; i < NumChan; i++) begin
      unique case (mode)
        MODE_SRC:      sum = {2'b00, s1[i]};
        MODE_SRCOVER:  sum = {2'b00, s1[i]} + {2'b00, div255r(p_dsa[i])};
        MODE_DSTOVER:  sum = {2'b00, d1[i]} + {2'b00, div255r(p_sda[i])};
        MODE_MULTIPLY: sum = {2'b00, div255r(p_sd[i])} + {2'b00, div255r(p_sda[i])}
                             + {2'b00, div255r(p_dsa[i])};
        default:       sum = {2'b00, s1[i]};
      endcase
      blend_next[i] = (sum > {2'b00, ChanMax}) ? ChanMax : sum[ChanW-1:0];
    end
  end

  // Stage two: saturated blend result with the destination carried along.
  always_ff @(posedge clk) begin
    if (v1 && rdy2) begin
      out_word.blend <= blend_next;
      out_word.dst   <= d1;
      out_word.cov   <= cov1;
    end
  end

  assign out_valid = v2;

endmodule

### hdl/pbc_cover.sv
// Coverage half of the pipeline: stage three forms |blend - dst| * cov,
// stage four rounds by 1/255 and moves dst towards the blend. Uses pbc_pkg.
module pbc_cover import pbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  blend_word_t in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output pix_t        out_pix
);

  logic                   v3, v4;
  logic                   rdy3, rdy4;
  pix_t                   blend3, dst3;
  logic [NumChan-1:0]     neg3;
  logic                   full3;
  prod_t                  mag3;
  pix_t                   pix_next;

  assign rdy4     = !v4 || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign in_ready = rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy3) v3 <= in_valid;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy3) begin
      blend3 <= in_word.blend;
      dst3   <= in_word.dst;
      full3  <= (in_word.cov == ChanMax);
      for (int i = 0; i < NumChan; i++) begin
        neg3[i] <= in_word.blend[i] < in_word.dst[i];
        if (in_word.blend[i] < in_word.dst[i]) begin
          mag3[i] <= (in_word.dst[i] - in_word.blend[i]) * in_word.cov;
        end else begin
          mag3[i] <= (in_word.blend[i] - in_word.dst[i]) * in_word.cov;
        end
      end
    end
  end

  // The rounded step never carries the result outside 0..255.
  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      if (full3) begin
        pix_next[i] = blend3[i];
      end else if (neg3[i]) begin
        pix_next[i] = dst3[i] - div255r(mag3[i]);
      end else begin
        pix_next[i] = dst3[i] + div255r(mag3[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && rdy4) begin
      out_pix <= pix_next;
    end
  end

  assign out_valid = v4;

endmodule

### hdl/pixel_blend_coverage.sv
// Porter-Duff blend of one source colour onto one RGBA8888 destination
// pixel, followed by a coverage mix towards the destination. It takes one
// word per clock unless the output stalls, and each word passes through
// four register stages: channel products, blend scaling and saturation,
// coverage product, coverage rounding. The mode register resets to source
// over and should only be written while the pipeline is empty.
// Depends on pbc_pkg, pbc_blend and pbc_cover.
module pixel_blend_coverage import pbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // src_red, src_green, src_blue, src_alpha, dst_pixel[31:0], coverage
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_pixel[31:0]
  output logic [31:0] m_axis_tdata
);

  blend_mode_t mode;
  logic        mid_valid, mid_ready;
  blend_word_t mid_word;
  pix_t        src, dst, out_pix;
  chan_t       cov;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_SRCOVER;
    end else if (cfg_wr_en) begin
      mode <= blend_mode_t'(cfg_wr_data);
    end
  end

  assign src = s_axis_tdata[31:0];
  assign dst = s_axis_tdata[63:32];
  assign cov = s_axis_tdata[71:64];

  pbc_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .src       (src),
    .dst       (dst),
    .cov       (cov),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_word  (mid_word)
  );

  pbc_cover u_cover (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_word   (mid_word),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_pix   (out_pix)
  );

  assign m_axis_tdata = out_pix;

  // An empty output stage must never hold back the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output stage");

  a_mode_write: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> mode == blend_mode_t'($past(cfg_wr_data)))
    else $error("blend mode write not taken");

  a_mode_reset: assert property (@(posedge clk)
    rst |=> mode == MODE_SRCOVER)
    else $error("blend mode not source over after reset");

  a_mid_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> mid_ready)
    else $error("coverage half stalled with an empty output stage");

endmodule

### tb/sv/pixel_blend_coverage_tb.sv
// Self-checking bench for pixel_blend_coverage: drives blend words under
// every mode with random idling on both streams and checks each output pixel.
// Depends on pbc_pkg and the pixel_blend_coverage RTL.
module pixel_blend_coverage_tb import pbc_pkg::*; ();

  // Holds the blend mode and the queue of pixels still owed by the block.
  class pixel_scoreboard;
    blend_mode_t mode;
    logic [31:0] owed_pixels[$];
    int unsigned fails;

    function new();
      mode = MODE_SRCOVER;
      fails = 0;
    endfunction

    function int unsigned scale255(int unsigned x);
      return (x + 127) / 255;
    endfunction

    function chan_t blend_chan(int unsigned s, int unsigned d, int unsigned sa,
                               int unsigned da);
      int unsigned v;
      case (mode)
        MODE_SRC:      v = s;
        MODE_SRCOVER:  v = s + scale255(d * (255 - sa));
        MODE_DSTOVER:  v = d + scale255(s * (255 - da));
        default:       v = scale255(s * d) + scale255(s * (255 - da)) +
                           scale255(d * (255 - sa));
      endcase
      return (v > 255) ? ChanMax : chan_t'(v);
    endfunction

    // Moves the destination towards the blended value by cov/255, with the
    // step rounded half away from zero.
    function chan_t cover_chan(int unsigned o, int unsigned d, int unsigned cov);
      if (cov == 255)
        return chan_t'(o);
      if (o >= d)
        return chan_t'(d + scale255((o - d) * cov));
      return chan_t'(d - scale255((d - o) * cov));
    endfunction

    function logic [31:0] blend_pixel(logic [71:0] w);
      pix_t  src;
      pix_t  dst;
      pix_t  res;
      chan_t cov;
      chan_t b;
      src = w[31:0];
      dst = w[63:32];
      cov = w[71:64];
      for (int i = 0; i < NumChan; i++) begin
        b = blend_chan(src[i], dst[i], src[3], dst[3]);
        res[i] = cover_chan(b, dst[i], cov);
      end
      return res;
    endfunction

    function void note_word(logic [71:0] w);
      owed_pixels.push_back(blend_pixel(w));
    endfunction

    function void check_pixel(logic [31:0] got);
      logic [31:0] want;
      if (owed_pixels.size() == 0) begin
        $error("out_pixel: expected nothing, got %08h", got);
        fails++;
        return;
      end
      want = owed_pixels.pop_front();
      if (got !== want) begin
        $error("out_pixel: expected %08h, got %08h", want, got);
        fails++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = 2'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // src_red, src_green, src_blue, src_alpha, dst_pixel[31:0], coverage
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // out_pixel[31:0]
  logic [31:0] m_axis_tdata;

  bit no_gaps = 1'b0;
  pixel_scoreboard sb = new();

  pixel_blend_coverage uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

  // Accepted input words.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && s_axis_tvalid && s_axis_tready)
        sb.note_word(s_axis_tdata);
    end
  end

  // Output side: check accepted words, then decide on the next stall.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        sb.check_pixel(m_axis_tdata);
      m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 10);
    end
  end

  task automatic send_pixel(input pix_t src, input logic [31:0] dst, input chan_t cov);
    while (!no_gaps && $urandom_range(0, 99) < 10) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tdata  <= {cov, dst, src};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Holds the sender off until every owed pixel has come back. The wait before
  // the queue is tested lets the word accepted at the last edge reach it first.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.owed_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(input blend_mode_t m);
    cfg_wr_data <= m;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.mode = m;
  endtask

  function automatic chan_t rand_chan();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return ChanMax;
      default: return chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic chan_t rand_cov();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return ChanMax;
      default: return chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    blend_mode_t dir_modes[4];
    pix_t        src;
    pix_t        dst;
    dir_modes = '{MODE_SRCOVER, MODE_SRC, MODE_DSTOVER, MODE_MULTIPLY};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The first pass runs on the reset mode without a write.
    foreach (dir_modes[m]) begin
      if (m != 0) begin
        drain();
        write_mode(dir_modes[m]);
      end
      send_pixel(32'hffffffff, 32'h00000000, 8'd255);
      send_pixel(32'h00000000, 32'hffffffff, 8'd255);
      send_pixel(32'h80604020, 32'h40c0a0e0, 8'd0);
      send_pixel(32'h00ff7f01, 32'h12345678, 8'd128);
      send_pixel(32'hff010101, 32'hffffffff, 8'd1);
      send_pixel(32'h807f10c8, 32'h00ff0010, 8'd254);
    end

    for (int p = 0; p < 6; p++) begin
      drain();
      write_mode(blend_mode_t'($urandom_range(0, 3)));
      no_gaps = (p == 2);
      repeat (250) begin
        for (int c = 0; c < NumChan; c++) begin
          src[c] = rand_chan();
          dst[c] = rand_chan();
        end
        send_pixel(src, dst, rand_cov());
      end
      no_gaps = 1'b0;
    end

    drain();
    if (sb.fails == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
